// File: rtl/core/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Types and constants shared by the periodic command scheduler modules.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int USED_W = 5;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 64;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ENQ = 1'b1;

  // input beat payload, cmd_kind in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] limit;
    logic [15:0] interval;
    logic [15:0] delay;
    logic [31:0] payload;
    logic [15:0] target;
    logic [1:0]  kind;
  } in_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [31:0] payload;
    logic [15:0] delay_left;
    logic [15:0] interval;
    logic [15:0] wait_left;
    logic [15:0] limit;
    logic [15:0] runs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // fields of one result beat other than the handshake flags
  typedef struct packed {
    logic [USED_W-1:0] used;
    logic              retired;
    logic [31:0]       payload;
    logic [15:0]       target;
    logic [1:0]        kind;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic enq;
    logic start;
    logic rd_slot;
    logic rd_last;
    logic eval;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic more;
    logic fire;
    logic retire;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/pcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ram
// Generic single write port ram with one registered read port.
// ----------------------------------------------------------------------------
module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/pcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer for enqueue and table walk of the command scheduler.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  pcs_pkg::stat_t st,
  output pcs_pkg::ctl_t  cmd
);

  pcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      pcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == pcs_pkg::OP_ENQ) begin
            cmd.enq = 1'b1;
            state_next = pcs_pkg::ST_FINISH;
          end else begin
            cmd.start = 1'b1;
            state_next = pcs_pkg::ST_READ;
          end
        end
      end
      pcs_pkg::ST_READ: begin
        if (st.more) begin
          cmd.rd_slot = 1'b1;
          state_next = pcs_pkg::ST_EVAL;
        end else begin
          state_next = pcs_pkg::ST_FINISH;
        end
      end
      pcs_pkg::ST_EVAL: begin
        // a new firing pushes the held one out, so wait for room
        if (!(st.fire && st.pend_valid && !st.out_free)) begin
          cmd.eval = 1'b1;
          state_next = st.retire ? pcs_pkg::ST_FETCH : pcs_pkg::ST_READ;
        end
      end
      pcs_pkg::ST_FETCH: begin
        if (st.more) begin
          cmd.rd_last = 1'b1;
          state_next = pcs_pkg::ST_EVAL;
        end else begin
          state_next = pcs_pkg::ST_FINISH;
        end
      end
      pcs_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = pcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/pcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_datapath
// Entry table, walk index, held result and output register.
// ----------------------------------------------------------------------------
module pcs_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pcs_pkg::IN_DATA_W-1:0]     in_data,
  input  pcs_pkg::ctl_t                     cmd,
  output pcs_pkg::stat_t                    st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcs_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_fired,
  output logic                              out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int UW = pcs_pkg::USED_W;

  pcs_pkg::in_t    in_item;
  pcs_pkg::entry_t rd_entry;
  pcs_pkg::entry_t wb_entry;
  pcs_pkg::entry_t enq_entry;
  pcs_pkg::entry_t wdata;
  pcs_pkg::res_t   pend;
  pcs_pkg::res_t   out_res;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] count_after;
  logic          pend_valid;
  logic          rejected;
  logic          out_rejected;
  logic          full;
  logic          fire;
  logic          retire;
  logic [16:0]   runs_inc;
  logic          out_free;
  logic          push_eval;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [pcs_pkg::ENTRY_W-1:0] rdata;

  assign in_item  = pcs_pkg::in_t'(in_data);
  assign rd_entry = pcs_pkg::entry_t'(rdata);

  assign full     = (count == CW'(TABLE_DEPTH));
  assign out_free = !out_valid || out_ready;

  // evaluation of the entry just read
  assign runs_inc = {1'b0, rd_entry.runs} + 17'd1;
  assign fire     = (rd_entry.delay_left == 16'd0) && (rd_entry.wait_left == 16'd0);
  assign retire   = fire && (runs_inc >= {1'b0, rd_entry.limit});
  assign count_after = retire ? count - CW'(1) : count;

  always_comb begin
    wb_entry = rd_entry;
    if (rd_entry.delay_left != 16'd0) begin
      wb_entry.delay_left = rd_entry.delay_left - 16'd1;
    end else if (rd_entry.wait_left != 16'd0) begin
      wb_entry.wait_left = rd_entry.wait_left - 16'd1;
    end else begin
      wb_entry.runs = runs_inc[15:0];
      wb_entry.wait_left = rd_entry.interval;
    end
  end

  always_comb begin
    enq_entry = '0;
    enq_entry.kind = in_item.kind;
    enq_entry.target = in_item.target;
    enq_entry.payload = in_item.payload;
    enq_entry.delay_left = in_item.delay;
    enq_entry.interval = (in_item.interval == 16'd0) ? 16'd1 : in_item.interval;
    enq_entry.limit = (in_item.limit == 16'd0) ? 16'd1 : in_item.limit;
  end

  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = wb_entry;
    if (cmd.enq && !full) begin
      we = 1'b1;
      waddr = count[AW-1:0];
      wdata = enq_entry;
    end else if (cmd.eval && !retire) begin
      we = 1'b1;
    end
  end

  // after a retirement count already points at the former last slot
  assign raddr = cmd.rd_last ? count[AW-1:0] : idx[AW-1:0];

  pcs_ram #(
    .WIDTH(pcs_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_slot || cmd.rd_last),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
      pend_valid <= 1'b0;
      rejected <= 1'b0;
    end else begin
      if (cmd.enq) begin
        rejected <= full;
        pend_valid <= 1'b0;
        if (!full) begin
          count <= count + CW'(1);
        end
      end
      if (cmd.start) begin
        idx <= '0;
        rejected <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.eval) begin
        count <= count_after;
        if (!retire) begin
          idx <= idx + CW'(1);
        end
        if (fire) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // held firing, sent once the next firing or the end of the walk shows up
  always_ff @(posedge clk) begin
    if (cmd.eval && fire) begin
      pend.kind <= rd_entry.kind;
      pend.target <= rd_entry.target;
      pend.payload <= rd_entry.payload;
      pend.retired <= retire;
      pend.used <= UW'(count_after);
    end
  end

  assign push_eval = cmd.eval && fire && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_eval || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_eval) begin
      out_res <= pend;
      out_fired <= 1'b1;
      out_rejected <= 1'b0;
      out_last <= 1'b0;
    end else if (cmd.finish) begin
      out_last <= 1'b1;
      if (pend_valid) begin
        out_res <= pend;
        out_fired <= 1'b1;
        out_rejected <= 1'b0;
      end else begin
        out_res <= '0;
        out_res.used <= UW'(count);
        out_fired <= 1'b0;
        out_rejected <= rejected;
      end
    end
  end

  assign out_data = {7'd0, out_res.used, out_rejected, out_res.retired,
                     out_res.payload, out_res.target, out_res.kind};

  assign st.more = (idx < count);
  assign st.fire = fire;
  assign st.retire = retire;
  assign st.pend_valid = pend_valid;
  assign st.out_free = out_free;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= count)
    else $error("walk index past entry count");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_eval |-> out_free)
    else $error("held result pushed over an untaken beat");

  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("final result pushed over an untaken beat");

endmodule

// File: rtl/core/periodic_command_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_command_scheduler
// Table of delayed, repeating commands; enqueue appends, tick walks and fires.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                             tuser
//  s_axis   in   cmd_kind, target, payload, start_delay,          opcode
//                repeat_interval, repeat_limit
//  m_axis   out  out_kind, out_target, out_payload, retired,      fired
//                rejected, entries_used (tlast = last)
//
// enqueue: the accept state writes the entry and the finish state sends the result.
// tick: each entry looked at takes a read state and an evaluate state, set by the single
// registered read port of the entry ram; a retirement costs nothing extra since
// the moved entry takes the place of a later read.
// reset clears the entry count and the control state; the ram holds no reset state.
// one result beat is held in the output register; the walk stalls when a
// second firing result finds it still untaken.
// ----------------------------------------------------------------------------
module periodic_command_scheduler #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd_kind[1:0], target[17:2], payload[49:18], start_delay[65:50],
  // repeat_interval[81:66], repeat_limit[97:82], zero fill above
  input  logic [pcs_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_kind[1:0], out_target[17:2], out_payload[49:18], retired[50],
  // rejected[51], entries_used[56:52], zero fill above
  output logic [pcs_pkg::OUT_DATA_W-1:0]  m_tdata,
  // fired
  output logic                            m_tuser,
  output logic                            m_tlast
);

  pcs_pkg::ctl_t  cmd;
  pcs_pkg::stat_t st;

  pcs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_op   (s_tuser),
    .in_ready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  pcs_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .out_fired(m_tuser),
    .out_last (m_tlast)
  );

endmodule

// File: dv/periodic_command_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_command_scheduler_test
// Drives enqueue and tick beats into the scheduler. A table model in the
// bench predicts every result beat: firings, retirements with the last
// entry moving into the freed slot, full-table rejects and status beats.
// Each result beat is checked field by field as it is taken. Both sides of
// the stream idle at random, and one long output stall backs up the block.
// ----------------------------------------------------------------------------
module periodic_command_scheduler_test;

  localparam int DEPTH = 16;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  kind;
    logic [15:0] target;
    logic [31:0] payload;
    logic [15:0] delay;
    logic [15:0] interval;
    logic [15:0] limit;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [31:0] payload;
    logic [15:0] delay_left;
    logic [15:0] interval;
    logic [15:0] wait_left;
    logic [15:0] limit;
    logic [15:0] runs;
  } slot_t;

  typedef struct packed {
    logic        fired;
    logic [1:0]  kind;
    logic [15:0] target;
    logic [31:0] payload;
    logic        retired;
    logic        rejected;
    logic [4:0]  used;
    logic        last;
  } sched_beat_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [pcs_pkg::IN_DATA_W-1:0]   s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [pcs_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  slot_t        slots [DEPTH];
  int unsigned  slot_count;
  sched_beat_t  firing_log [$];
  int unsigned  mismatch_count;
  int unsigned  hold_left;
  int unsigned  burst_left;
  bit           sender_idles;

  periodic_command_scheduler #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sched_cmd_t make_tick();
    sched_cmd_t c;
    c = '0;
    c.opcode = pcs_pkg::OP_TICK;
    return c;
  endfunction

  function automatic sched_cmd_t make_enq(logic [1:0] kind, logic [15:0] target,
                                          logic [31:0] payload, logic [15:0] delay,
                                          logic [15:0] interval, logic [15:0] limit);
    sched_cmd_t c;
    c.opcode = pcs_pkg::OP_ENQ;
    c.kind = kind;
    c.target = target;
    c.payload = payload;
    c.delay = delay;
    c.interval = interval;
    c.limit = limit;
    return c;
  endfunction

  // table model: appends on enqueue, walks and fires on tick
  task automatic run_schedule(input sched_cmd_t c);
    sched_beat_t beats [$];
    sched_beat_t b;
    int unsigned i;
    logic [16:0] runs_next;
    b = '0;
    if (c.opcode == pcs_pkg::OP_ENQ) begin
      if (slot_count >= DEPTH) begin
        b.rejected = 1'b1;
      end else begin
        slots[slot_count].kind = c.kind;
        slots[slot_count].target = c.target;
        slots[slot_count].payload = c.payload;
        slots[slot_count].delay_left = c.delay;
        slots[slot_count].interval = (c.interval == 16'd0) ? 16'd1 : c.interval;
        slots[slot_count].wait_left = 16'd0;
        slots[slot_count].limit = (c.limit == 16'd0) ? 16'd1 : c.limit;
        slots[slot_count].runs = 16'd0;
        slot_count++;
      end
      b.used = slot_count[4:0];
      b.last = 1'b1;
      firing_log.push_back(b);
      return;
    end
    i = 0;
    while (i < slot_count) begin
      if (slots[i].delay_left != 16'd0) begin
        slots[i].delay_left--;
        i++;
      end else if (slots[i].wait_left != 16'd0) begin
        slots[i].wait_left--;
        i++;
      end else begin
        b = '0;
        b.fired = 1'b1;
        b.kind = slots[i].kind;
        b.target = slots[i].target;
        b.payload = slots[i].payload;
        runs_next = {1'b0, slots[i].runs} + 17'd1;
        if (runs_next >= {1'b0, slots[i].limit}) begin
          // last entry fills the hole and is looked at next
          slots[i] = slots[slot_count-1];
          slot_count--;
          b.retired = 1'b1;
        end else begin
          slots[i].runs = runs_next[15:0];
          slots[i].wait_left = slots[i].interval;
          i++;
        end
        b.used = slot_count[4:0];
        beats.push_back(b);
      end
    end
    if (beats.size() == 0) begin
      b = '0;
      b.used = slot_count[4:0];
      beats.push_back(b);
    end
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[k]) firing_log.push_back(beats[k]);
  endtask

  task automatic send_cmd(input sched_cmd_t c);
    pcs_pkg::in_t word;
    int unsigned gap;
    word = '0;
    word.kind = c.kind;
    word.target = c.target;
    word.payload = c.payload;
    word.delay = c.delay;
    word.interval = c.interval;
    word.limit = c.limit;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = word;
    s_tuser = c.opcode;
    do @(posedge clk); while (!s_tready);
    run_schedule(c);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_idles) gap = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic sched_cmd_t random_enq();
    logic [15:0] delay;
    logic [15:0] interval;
    logic [15:0] limit;
    delay = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 20))
                                         : 16'($urandom_range(0, 3));
    interval = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 12))
                                            : 16'($urandom_range(0, 4));
    limit = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 10))
                                         : 16'($urandom_range(0, 4));
    return make_enq(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                    delay, interval, limit);
  endfunction

  task automatic test_empty_tick();
    send_cmd(make_tick());
  endtask

  task automatic test_single_fire();
    // all-ones kind, target and payload, fires on the first tick and retires at once
    send_cmd(make_enq(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'd1));
    send_cmd(make_tick());
  endtask

  task automatic test_countdown();
    // parked entry: maximal delay, interval and limit, never fires in this run
    send_cmd(make_enq(2'd2, 16'h5A5A, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // zero interval acts as one, so it fires every other tick after its delay
    send_cmd(make_enq(2'd0, 16'h0000, 32'h0000_0000, 16'd1, 16'd0, 16'd3));
    repeat (4) send_cmd(make_tick());
  endtask

  task automatic test_full_table();
    while (slot_count < DEPTH)
      send_cmd(make_enq(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                        16'd0, 16'd0, 16'd0));
    send_cmd(make_enq(2'd1, 16'hBEEF, 32'hCAFE_F00D, 16'd0, 16'd0, 16'd0));
    // every one-shot entry retires in one walk, each hole refilled from the end
    send_cmd(make_tick());
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    for (n = 0; n < 100; n++) begin
      if (n % 30 == 0) sender_idles = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 15) < slot_count / 2 + 3)
        send_cmd(make_tick());
      else
        send_cmd(random_enq());
    end
  endtask

  task automatic test_output_stall();
    int unsigned n;
    sender_idles = 1'b0;
    @(posedge clk);
    hold_left = 300;
    for (n = 0; n < 24; n++) begin
      if (n % 6 == 5)
        send_cmd(make_tick());
      else
        send_cmd(make_enq(2'($urandom_range(0, 3)), 16'($urandom), $urandom, 16'd0,
                          16'($urandom_range(0, 2)), 16'($urandom_range(0, 2))));
    end
    sender_idles = 1'b1;
  endtask

  // receiver: switches at random between ready patterns, or holds off
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned left;
    int unsigned phase;
    m_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          RX_OPEN: m_tready = 1'b1;
          RX_COIN: m_tready = 1'($urandom_range(0, 1));
          RX_THIRD: begin
            phase = (phase + 1) % 3;
            m_tready = (phase == 0);
          end
          default: m_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_beats
    sched_beat_t want;
    sched_beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.fired = m_tuser;
      got.kind = m_tdata[1:0];
      got.target = m_tdata[17:2];
      got.payload = m_tdata[49:18];
      got.retired = m_tdata[50];
      got.rejected = m_tdata[51];
      got.used = m_tdata[56:52];
      got.last = m_tlast;
      if (firing_log.size() == 0) begin
        $display("%0t: result beat, expected none, actual tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = firing_log.pop_front();
        if (got.fired !== want.fired)
          report_mismatch("fired", 32'(want.fired), 32'(got.fired));
        if (got.kind !== want.kind)
          report_mismatch("out_kind", 32'(want.kind), 32'(got.kind));
        if (got.target !== want.target)
          report_mismatch("out_target", 32'(want.target), 32'(got.target));
        if (got.payload !== want.payload)
          report_mismatch("out_payload", want.payload, got.payload);
        if (got.retired !== want.retired)
          report_mismatch("retired", 32'(want.retired), 32'(got.retired));
        if (got.rejected !== want.rejected)
          report_mismatch("rejected", 32'(want.rejected), 32'(got.rejected));
        if (got.used !== want.used)
          report_mismatch("entries_used", 32'(want.used), 32'(got.used));
        if (got.last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = pcs_pkg::OP_TICK;
    slot_count = 0;
    mismatch_count = 0;
    hold_left = 0;
    burst_left = 0;
    sender_idles = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_tick();
    test_single_fire();
    test_countdown();
    test_full_table();
    test_random_traffic();
    test_output_stall();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (firing_log.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d result beats outstanding", $time, firing_log.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_ram.sv
rtl/core/pcs_ctrl.sv
rtl/core/pcs_datapath.sv
rtl/core/periodic_command_scheduler.sv
dv/periodic_command_scheduler_test.sv
